FILE: rtl/tcw_pkg.sv
// Shared definitions for the text console writer: geometry, request codes,
// register map and the cell memory port bundle. No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam int COL_W      = $clog2(COLUMNS + 1);
  localparam int CELL_W     = 16;

  // Cell layout
  localparam logic [7:0]        NEWLINE_CODE = 8'h0A;
  localparam logic [CELL_W-1:0] COLOUR_MASK  = 16'hFF00;
  localparam int                BACK_SHIFT   = 12;
  localparam int                FORE_SHIFT   = 8;

  // Register reset values and the cell that reset leaves everywhere
  localparam logic [3:0]        FORE_RST = 4'hF;
  localparam logic [3:0]        BACK_RST = 4'h0;
  localparam logic [CELL_W-1:0] RST_CELL = (CELL_W'(BACK_RST) << BACK_SHIFT) |
                                           (CELL_W'(FORE_RST) << FORE_SHIFT);

  // Configuration port
  localparam int   PADDR_W  = 3;
  localparam logic REG_FORE = 1'b0;
  localparam logic REG_BACK = 1'b1;

  // Request codes
  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  // One write port and one read port of the cell memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: rtl/tcw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; used for the console cell buffer.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tcw_seq.sv
// Request sequencer of the text console writer: cursor, sweeps for reset,
// clear and scroll, and read-modify-write of single cells. Uses tcw_pkg.
`timescale 1ns / 1ps

module tcw_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type,
  input  logic [7:0]                   char_code,
  input  logic [3:0]                   clear_color,
  input  logic [10:0]                  cell_index,
  input  logic [3:0]                   fore_color,
  output logic                         out_valid,
  output logic [15:0]                  out_cell_data,
  output logic [4:0]                   out_cursor_row,
  output logic [6:0]                   out_cursor_col,
  output tcw_pkg::mem_req_t            mem_req,
  input  logic [tcw_pkg::CELL_W-1:0]   mem_rdata
);

  typedef enum logic [6:0] {
    ST_INIT      = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_PUT_ISSUE = 7'b0000100,
    ST_PUT_WB    = 7'b0001000,
    ST_SCROLL    = 7'b0010000,
    ST_FILL      = 7'b0100000,
    ST_READ_WAIT = 7'b1000000
  } state_t;

  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_ADDR =
    tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);

  state_t                          state_r, state_nxt;
  logic [tcw_pkg::ADDR_W-1:0]      sweep_r, sweep_nxt;
  logic [tcw_pkg::ROW_W-1:0]       row_r, row_nxt;
  logic [tcw_pkg::COL_W-1:0]       col_r, col_nxt;
  logic [7:0]                      ch_r, ch_nxt;
  logic [tcw_pkg::CELL_W-1:0]      fill_val_r, fill_val_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [15:0]                     out_data_r, out_data_nxt;
  logic                            wb_v_r, wb_v_nxt;
  logic [tcw_pkg::ADDR_W-1:0]      wb_addr_r, wb_addr_nxt;
  logic                            wb_keep_r, wb_keep_nxt;

  logic [tcw_pkg::ROW_W-1:0]       row_wrap;
  logic [tcw_pkg::COL_W-1:0]       col_wrap;
  logic [tcw_pkg::ADDR_W-1:0]      cur_idx;

  // Cursor after the end-of-line wrap, and the cell under the cursor
  always_comb begin
    if (32'(col_r) >= tcw_pkg::COLUMNS) begin
      row_wrap = tcw_pkg::ROW_W'(32'(row_r) + 1);
      col_wrap = '0;
    end else begin
      row_wrap = row_r;
      col_wrap = col_r;
    end
    cur_idx = tcw_pkg::ADDR_W'(32'(row_r) * tcw_pkg::COLUMNS + 32'(col_r));
  end

  // Next state and memory port. The scroll sweep writes each cell in the cycle
  // after its read; writes always trail reads to lower addresses, so no
  // access to the same cell ever overlaps.
  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ch_nxt        = ch_r;
    fill_val_nxt  = fill_val_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wb_v_nxt      = 1'b0;
    wb_addr_nxt   = wb_addr_r;
    wb_keep_nxt   = wb_keep_r;

    mem_req.we    = wb_v_r;
    mem_req.waddr = wb_addr_r;
    mem_req.wdata = wb_keep_r ? (mem_rdata & tcw_pkg::COLOUR_MASK) : mem_rdata;
    mem_req.raddr = cur_idx;

    case (state_r)
      ST_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sweep_r;
        mem_req.wdata = tcw_pkg::RST_CELL;
        if (sweep_r == LAST_ADDR) begin
          sweep_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          case (req_type)
            tcw_pkg::REQ_PUT: begin
              ch_nxt  = char_code;
              col_nxt = col_wrap;
              if (32'(row_wrap) >= tcw_pkg::ROWS) begin
                // The row left after the scroll has moved everything up
                row_nxt   = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                sweep_nxt = '0;
                state_nxt = ST_SCROLL;
              end else begin
                row_nxt   = row_wrap;
                state_nxt = ST_PUT_ISSUE;
              end
            end
            tcw_pkg::REQ_CLEAR: begin
              fill_val_nxt =
                (tcw_pkg::CELL_W'(clear_color) << tcw_pkg::BACK_SHIFT) |
                (tcw_pkg::CELL_W'(fore_color) << tcw_pkg::FORE_SHIFT);
              sweep_nxt = '0;
              state_nxt = ST_FILL;
            end
            tcw_pkg::REQ_READ: begin
              if (32'(cell_index) < tcw_pkg::CELL_COUNT) begin
                mem_req.raddr = tcw_pkg::ADDR_W'(cell_index);
                state_nxt     = ST_READ_WAIT;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
            end
          endcase
        end
      end

      ST_SCROLL: begin
        // Rows below the top move up; the bottom row keeps only its colours
        wb_v_nxt    = 1'b1;
        wb_addr_nxt = sweep_r;
        if (32'(sweep_r) < tcw_pkg::MOVE_COUNT) begin
          mem_req.raddr = sweep_r + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
          wb_keep_nxt   = 1'b0;
        end else begin
          mem_req.raddr = sweep_r;
          wb_keep_nxt   = 1'b1;
        end
        if (sweep_r == LAST_ADDR) begin
          sweep_nxt = '0;
          state_nxt = ST_PUT_ISSUE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      ST_PUT_ISSUE: begin
        if (ch_r == tcw_pkg::NEWLINE_CODE) begin
          row_nxt       = tcw_pkg::ROW_W'(32'(row_r) + 1);
          col_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_PUT_WB;
        end
      end

      ST_PUT_WB: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cur_idx;
        mem_req.wdata = (mem_rdata & tcw_pkg::COLOUR_MASK) |
                        tcw_pkg::CELL_W'(ch_r);
        col_nxt       = tcw_pkg::COL_W'(32'(col_r) + 1);
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        state_nxt     = ST_IDLE;
      end

      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sweep_r;
        mem_req.wdata = fill_val_r;
        if (sweep_r == LAST_ADDR) begin
          sweep_nxt     = '0;
          row_nxt       = '0;
          col_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      ST_READ_WAIT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = 16'(mem_rdata);
        state_nxt     = ST_IDLE;
      end

      default: begin
        sweep_nxt = '0;
        state_nxt = ST_INIT;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
      wb_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
      wb_v_r      <= wb_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    fill_val_r <= fill_val_nxt;
    out_data_r <= out_data_nxt;
    wb_addr_r  <= wb_addr_nxt;
    wb_keep_r  <= wb_keep_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cell_data  = out_data_r;
  assign out_cursor_row = 5'(row_r);
  assign out_cursor_col = 7'(col_r);

`ifndef SYNTHESIS
  // A result beat is only ever shown with the sequencer back at rest
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result beat shown while the sequencer is busy");

  // No cell is read in the same cycle as it is written during a scroll sweep or its last write-back
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCROLL) || (state_r == ST_PUT_ISSUE)) && mem_req.we
      |-> (mem_req.waddr != mem_req.raddr))
    else $error("cell read and written in the same cycle");

  // At rest the cursor stays inside the buffer, with a full row only at column 0
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ((32'(row_r) <= tcw_pkg::ROWS) &&
      (32'(col_r) <= tcw_pkg::COLUMNS) &&
      !((32'(row_r) == tcw_pkg::ROWS) && (col_r != '0))))
    else $error("cursor outside the buffer");

  // After a scroll the character goes into the bottom row
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL) && (sweep_r == LAST_ADDR)
      |=> (state_r == ST_PUT_ISSUE) && (32'(row_r) == tcw_pkg::ROWS - 1))
    else $error("scroll did not end on the bottom row");
`endif

endmodule

FILE: rtl/text_console_writer_unit.sv
// Top level of the text console writer: configuration registers, request
// sequencer and cell memory. Depends on tcw_pkg, tcw_ram and tcw_seq.
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// request   start, busy               in_req_type, in_char_code, in_clear_color,
//                                     in_cell_index
// result    out_valid (one cycle)     out_cell_data, out_cursor_row, out_cursor_col
// config    psel, penable, pwrite,    paddr, pwdata, prdata
//           pready (always high)
//
// A character goes through PUT_ISSUE and PUT_WB to its result beat, a newline
// through PUT_ISSUE and a cell read through READ_WAIT; an unused code or an
// out-of-range read is answered from idle. A character's cell is read through
// the registered memory read port and written back. A clear writes one cell a
// cycle; a put that scrolls first runs a copy sweep over the whole buffer.
// After reset the buffer is filled one cell a cycle, with busy high, and
// configuration writes are taken throughout.
// The receiver cannot stall: each result beat is valid for one cycle only.

module text_console_writer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_req_type,
  input  logic [7:0]                  in_char_code,
  input  logic [3:0]                  in_clear_color,
  input  logic [10:0]                 in_cell_index,
  output logic                        out_valid,
  output logic [15:0]                 out_cell_data,
  output logic [4:0]                  out_cursor_row,
  output logic [6:0]                  out_cursor_col,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [3:0]                 fore_r, fore_nxt;
  logic [3:0]                 back_r, back_nxt;
  logic                       cfg_wr;
  tcw_pkg::mem_req_t          mem_req;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  // Configuration registers; byte lanes within a word are ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    fore_nxt = fore_r;
    back_nxt = back_r;
    if (cfg_wr) begin
      if (paddr[2] == tcw_pkg::REG_BACK) begin
        back_nxt = pwdata[3:0];
      end else begin
        fore_nxt = pwdata[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r <= tcw_pkg::FORE_RST;
      back_r <= tcw_pkg::BACK_RST;
    end else begin
      fore_r <= fore_nxt;
      back_r <= back_nxt;
    end
  end

  assign prdata = (paddr[2] == tcw_pkg::REG_BACK) ? 32'(back_r) : 32'(fore_r);

  // Request sequencer
  tcw_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .req_type       (in_req_type),
    .char_code      (in_char_code),
    .clear_color    (in_clear_color),
    .cell_index     (in_cell_index),
    .fore_color     (fore_r),
    .out_valid      (out_valid),
    .out_cell_data  (out_cell_data),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  // Cell buffer
  tcw_ram #(
    .DEPTH (tcw_pkg::CELL_COUNT),
    .WIDTH (tcw_pkg::CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: dv/tb_text_console_writer_unit.sv
// Self-checking testbench for text_console_writer_unit: drives put, clear, read and
// spare requests plus register writes, and checks every result beat. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tb_text_console_writer_unit;
  import tcw_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_FORE = {REG_FORE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_BACK = {REG_BACK, 2'b00};
  localparam int STALL_LIMIT = 20000;
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 408;
  localparam int CALM_ITEMS  = 150;
  localparam int TAIL_CYCLES = 16;
  localparam int PRINT_CAP   = 40;

  // One expected result beat.
  typedef struct {
    logic [CELL_W-1:0] cell_val;
    logic [4:0]        row;
    logic [6:0]        col;
  } status_t;

  // Shadow of the console: screen contents, cursor and foreground register.
  class console_shadow;
    logic [CELL_W-1:0] screen [CELL_COUNT];
    int unsigned       row_at;
    int unsigned       col_at;
    logic [3:0]        fore;
    status_t           pending_status [$];
    int                errors;

    function new();
      fore   = FORE_RST;
      row_at = 0;
      col_at = 0;
      errors = 0;
      foreach (screen[i]) screen[i] = RST_CELL;
    endfunction

    function void paint_all(logic [3:0] back);
      foreach (screen[i])
        screen[i] = (CELL_W'(back) << BACK_SHIFT) | (CELL_W'(fore) << FORE_SHIFT);
    endfunction

    // Lines move up by one; the bottom line keeps its colours but loses its text.
    function void roll_up();
      for (int i = 0; i < MOVE_COUNT; i++) screen[i] = screen[i + COLUMNS];
      for (int i = MOVE_COUNT; i < CELL_COUNT; i++) screen[i] &= COLOUR_MASK;
      row_at--;
    endfunction

    function void place_glyph(logic [7:0] ch);
      int unsigned idx;
      if (col_at >= COLUMNS) begin
        row_at++;
        col_at = 0;
      end
      if (row_at >= ROWS) begin
        row_at = ROWS;
        roll_up();
      end
      if (ch == NEWLINE_CODE) begin
        row_at++;
        col_at = 0;
      end else begin
        idx = row_at * COLUMNS + col_at;
        screen[idx] = (screen[idx] & COLOUR_MASK) | CELL_W'(ch);
        col_at++;
      end
    endfunction

    // Applies an accepted request beat and queues the status it must produce.
    function void note_request(logic [1:0] req, logic [7:0] ch, logic [3:0] colour,
                               logic [10:0] idx);
      status_t s;
      s.cell_val = '0;
      case (req)
        REQ_PUT: place_glyph(ch);
        REQ_CLEAR: begin
          paint_all(colour);
          row_at = 0;
          col_at = 0;
        end
        REQ_READ: if (idx < CELL_COUNT) s.cell_val = screen[idx];
        default: ;
      endcase
      s.row = row_at[4:0];
      s.col = col_at[6:0];
      pending_status.push_back(s);
    endfunction

    task report_mismatch(string what);
      if (errors < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
      errors++;
    endtask

    task check_status(logic [CELL_W-1:0] cell_val, logic [4:0] row, logic [6:0] col);
      status_t want;
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing awaited (cell %h)", cell_val));
        return;
      end
      want = pending_status.pop_front();
      if (cell_val !== want.cell_val)
        report_mismatch($sformatf("cell_data %h, expected %h", cell_val, want.cell_val));
      if (row !== want.row)
        report_mismatch($sformatf("cursor_row %0d, expected %0d", row, want.row));
      if (col !== want.col)
        report_mismatch($sformatf("cursor_col %0d, expected %0d", col, want.col));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_req_type;
  logic [7:0]         in_char_code;
  logic [3:0]         in_clear_color;
  logic [10:0]        in_cell_index;
  logic               out_valid;
  logic [15:0]        out_cell_data;
  logic [4:0]         out_cursor_row;
  logic [6:0]         out_cursor_col;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  console_shadow board;
  int            line_left;
  int            quiet_cycles;
  bit            sender_lazy;

  text_console_writer_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_char_code   (in_char_code),
    .in_clear_color (in_clear_color),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_cell_data  (out_cell_data),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Every result beat is checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      board.check_status(out_cell_data, out_cursor_row, out_cursor_col);
  end

  // Watchdog: too long without a request or result beat ends the run.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || out_valid === 1'b1)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Presents one request and holds it until the block takes it.
  task automatic send_item(logic [1:0] req, logic [7:0] ch, logic [3:0] colour,
                           logic [10:0] idx);
    @(negedge clk);
    start          <= 1'b1;
    in_req_type    <= req;
    in_char_code   <= ch;
    in_clear_color <= colour;
    in_cell_index  <= idx;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    board.note_request(req, ch, colour, idx);
  endtask

  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Stops sending until every awaited beat has arrived and the block is idle.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending_status.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [3:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {28'($urandom_range(0, 32'h0FFF_FFFF)), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (addr == ADDR_FORE) board.fore = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly text made of lines of random length, ending in a newline; some lines
  // run to the wrap point. Reads, spare codes and rare clears are mixed in.
  task automatic random_item(bit calm);
    int          pick;
    int          shape;
    logic [1:0]  req;
    logic [7:0]  ch;
    logic [3:0]  colour;
    logic [10:0] idx;
    ch     = 8'($urandom_range(0, 255));
    colour = 4'($urandom_range(0, 15));
    idx    = 11'($urandom_range(0, 2047));
    pick   = $urandom_range(0, 999);
    if (pick < 2) begin
      req = REQ_CLEAR;
    end else if (pick < 32) begin
      req = REQ_SPARE;
    end else if (pick < 182) begin
      req = REQ_READ;
      if ($urandom_range(0, 4) != 0) idx = 11'($urandom_range(0, CELL_COUNT - 1));
    end else begin
      req = REQ_PUT;
      if (line_left == 0) begin
        ch    = NEWLINE_CODE;
        shape = $urandom_range(0, 99);
        if (shape < 35) line_left = 0;
        else if (shape < 45) line_left = COLUMNS;
        else if (shape < 50) line_left = $urandom_range(COLUMNS - 1, COLUMNS + 1);
        else line_left = $urandom_range(1, 12);
      end else begin
        line_left--;
      end
    end
    send_item(req, ch, colour, idx);
    if (!calm && $urandom_range(0, 99) == 0) drain();
    else if (!calm && sender_lazy && $urandom_range(0, 2) == 0)
      hold_off($urandom_range(1, 7));
  endtask

  initial begin
    logic [3:0] fore_pick;
    logic [3:0] back_pick;
    board          = new();
    line_left      = 0;
    quiet_cycles   = 0;
    sender_lazy    = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_req_type    = REQ_PUT;
    in_char_code   = '0;
    in_clear_color = '0;
    in_cell_index  = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats at the reset register values, sent back to back.
    send_item(REQ_READ, 8'h00, 4'h0, 11'd0);
    send_item(REQ_READ, 8'hFF, 4'hF, 11'd1999);
    send_item(REQ_READ, 8'h00, 4'h0, 11'd2000);
    send_item(REQ_READ, 8'hFF, 4'hF, 11'd2047);
    send_item(REQ_PUT, 8'h00, 4'hF, 11'd2047);
    send_item(REQ_PUT, 8'hFF, 4'h0, 11'd0);
    send_item(REQ_PUT, 8'h80, 4'h0, 11'd0);
    send_item(REQ_PUT, 8'h41, 4'h0, 11'd0);
    send_item(REQ_PUT, NEWLINE_CODE, 4'h0, 11'd0);
    send_item(REQ_PUT, 8'h0B, 4'h0, 11'd0);
    send_item(REQ_SPARE, 8'hFF, 4'hF, 11'd2047);
    send_item(REQ_READ, 8'h00, 4'h0, 11'd0);
    send_item(REQ_READ, 8'h00, 4'h0, 11'd3);
    send_item(REQ_READ, 8'h00, 4'h0, 11'd80);
    send_item(REQ_CLEAR, 8'h00, 4'hF, 11'd0);
    send_item(REQ_READ, 8'h00, 4'h0, 11'd0);
    send_item(REQ_PUT, 8'h09, 4'h0, 11'd0);
    send_item(REQ_CLEAR, 8'hFF, 4'h0, 11'd0);
    send_item(REQ_READ, 8'h00, 4'h0, 11'd1999);
    drain();

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      fore_pick = (p == 0) ? 4'h0 : (p == 1) ? 4'hF : 4'($urandom_range(0, 15));
      back_pick = (p == 0) ? 4'hF : (p == 1) ? 4'h0 : 4'($urandom_range(0, 15));
      write_reg(ADDR_FORE, fore_pick);
      write_reg(ADDR_BACK, back_pick);
      if (p % 2 == 1)
        send_item(REQ_CLEAR, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                  11'($urandom_range(0, 2047)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) sender_lazy = ($urandom_range(0, 2) != 0);
        random_item(p == PHASES - 1 && i >= PHASE_ITEMS - CALM_ITEMS);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.pending_status.size() != 0)
      board.report_mismatch($sformatf("%0d result beats never arrived",
                                      board.pending_status.size()));
    if (board.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
